// ===== hdl/wkalm_pkg.sv =====
// shared types, request codes and minute-of-week helper for the weekly alarm block
package wkalm_pkg;

  localparam int unsigned DAY_MIN  = 1440;
  localparam int unsigned HOUR_MIN = 60;
  localparam int unsigned WEEK_MIN = 10080;
  localparam int unsigned SLOT_W   = 5;   // wide enough for the largest slot count
  localparam int unsigned DIST_W   = 14;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_TIME  = 2'd2;
  localparam logic [1:0] REQ_STOP  = 2'd3;

  localparam logic [2:0] LAST_DAY = 3'd6;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] slot_index;
    logic [4:0] set_hour;
    logic [5:0] set_minute;
    logic [6:0] set_days;
    logic       set_enable;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
    logic [2:0] now_day;
  } in_t;

  typedef struct packed {
    logic              ringing;
    logic              ring_started;
    logic              ring_stopped;
    logic              next_valid;
    logic [2:0]        next_slot;
    logic [2:0]        next_weekday;
    logic [DIST_W-1:0] minutes_until;
  } out_t;

  typedef struct packed {
    logic       enable;
    logic [6:0] days;
    logic [5:0] minute;
    logic [4:0] hour;
  } alarm_t;

  typedef struct packed {
    logic              load;
    logic              mem_wr;
    logic              mem_rd;
    logic              rd_next;
    logic [SLOT_W-1:0] rd_addr;
    logic              scan_clr;
    logic              scan_eval;
    logic [SLOT_W-1:0] slot;
    logic [2:0]        day;
    logic              tick_eval;
    logic              done;
  } cmd_t;

  typedef struct packed {
    logic tick_rescan;
  } status_t;

  // minute of the week, one conditional subtract brings it into range
  function automatic logic [DIST_W-1:0] week_minute(input logic [2:0] day,
                                                    input logic [4:0] hour,
                                                    input logic [6:0] minute);
    logic [DIST_W:0] t;
    t = 15'(day) * 15'(DAY_MIN) + 15'(hour) * 15'(HOUR_MIN) + 15'(minute);
    if (t >= 15'(WEEK_MIN)) begin
      t = t - 15'(WEEK_MIN);
    end
    return t[DIST_W-1:0];
  endfunction

endpackage

// ===== hdl/wkalm_ctrl.sv =====
// sequencer for the weekly alarm block: request decode, scan counters, strobes
module wkalm_ctrl import wkalm_pkg::*; #(
  parameter int unsigned ALARM_SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] req_type,
  input  status_t    status,
  output logic       busy,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_READ, S_DAY, S_TICK_RD, S_TICK_EVAL, S_DONE
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] slot;
  logic [2:0]        day;
  logic              last_slot;

  assign last_slot = (slot == SLOT_W'(ALARM_SLOTS - 1));
  assign busy      = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot  <= '0;
      day   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          slot <= '0;
          day  <= '0;
          if (start) begin
            unique case (req_type)
              REQ_WRITE: state <= S_WRITE;
              REQ_TICK:  state <= S_TICK_RD;
              default:   state <= S_READ;
            endcase
          end
        end
        S_WRITE: state <= S_READ;
        S_READ: begin
          slot  <= '0;
          day   <= '0;
          state <= S_DAY;
        end
        S_DAY: begin
          if (day == LAST_DAY) begin
            day <= '0;
            if (last_slot) begin
              state <= S_DONE;
            end else begin
              slot <= slot + 1'b1;
            end
          end else begin
            day <= day + 1'b1;
          end
        end
        S_TICK_RD: state <= S_TICK_EVAL;
        S_TICK_EVAL: state <= status.tick_rescan ? S_READ : S_DONE;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && start;
    cmd.mem_wr    = (state == S_WRITE);
    cmd.scan_clr  = (state == S_READ);
    cmd.scan_eval = (state == S_DAY);
    cmd.slot      = slot;
    cmd.day       = day;
    cmd.tick_eval = (state == S_TICK_EVAL);
    cmd.done      = (state == S_DONE);
    cmd.rd_next   = (state == S_TICK_RD);
    cmd.mem_rd    = (state == S_READ) || (state == S_TICK_RD) ||
                    ((state == S_DAY) && (day == LAST_DAY) && !last_slot);
    // prefetch the following slot while the last day of this one is scored
    cmd.rd_addr   = (state == S_DAY) ? slot + 1'b1 : '0;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.done |=> !busy) else $error("done not followed by idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

endmodule

// ===== hdl/wkalm_dp.sv =====
// datapath for the weekly alarm block: alarm memory, nearest-alarm scan, ring flags
module wkalm_dp import wkalm_pkg::*; #(
  parameter int unsigned ALARM_SLOTS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  in_t     item,
  input  cmd_t    cmd,
  output status_t status,
  output out_t    result
);

  localparam int unsigned IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

  alarm_t                 mem [ALARM_SLOTS];
  logic [ALARM_SLOTS-1:0] vld;
  alarm_t                 rd_data;
  logic                   rd_vld;
  alarm_t                 entry;

  in_t               item_q;
  logic [DIST_W-1:0] from_q;
  logic [DIST_W-1:0] best;
  logic              next_present;
  logic [IDX_W-1:0]  next_index;
  logic [2:0]        next_day;
  logic [DIST_W-1:0] next_dist;
  logic              ring;
  logic              started;
  logic              stopped;

  logic [5:0]        wr_slot_ext;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_ok;
  logic [IDX_W-1:0]  rd_addr;
  logic [DIST_W-1:0] at_min;
  logic [DIST_W:0]   wrap_dist;
  logic [DIST_W-1:0] cand_dist;
  logic              day_hit;
  logic [7:0]        days_ext;
  logic              tick_match;
  logic              ring_new;
  logic [SLOT_W-1:0] next_index_ext;

  assign wr_slot_ext = {3'b000, item_q.slot_index};
  assign wr_addr     = wr_slot_ext[IDX_W-1:0];
  assign wr_ok       = (wr_slot_ext < 6'(ALARM_SLOTS));
  assign rd_addr     = cmd.rd_next ? next_index : cmd.rd_addr[IDX_W-1:0];
  assign entry       = rd_vld ? rd_data : '0;

  // alarm table, entries read as disabled until written
  always_ff @(posedge clk) begin
    if (cmd.mem_wr && wr_ok) begin
      mem[wr_addr] <= alarm_t'{enable: item_q.set_enable, days: item_q.set_days,
                               minute: item_q.set_minute, hour: item_q.set_hour};
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.mem_wr && wr_ok) begin
        vld[wr_addr] <= 1'b1;
      end
      if (cmd.mem_rd) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // scoring of one enabled day of the current slot
  assign at_min    = week_minute(cmd.day, entry.hour, {1'b0, entry.minute});
  assign wrap_dist = {1'b0, at_min} + (DIST_W + 1)'(WEEK_MIN) - {1'b0, from_q};
  assign cand_dist = (at_min >= from_q) ? at_min - from_q : wrap_dist[DIST_W-1:0];
  assign day_hit   = entry.enable && entry.days[cmd.day];

  // tick compare against the stored next alarm, day seven never matches
  assign days_ext   = {1'b0, entry.days};
  assign tick_match = next_present && days_ext[item_q.now_day] &&
                      (entry.hour == item_q.now_hour) &&
                      (entry.minute == item_q.now_minute);
  assign ring_new   = ring || (tick_match && (item_q.now_second == '0));
  assign status.tick_rescan = ring_new && !tick_match;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    if (cmd.scan_clr) begin
      from_q <= week_minute(item_q.now_day, item_q.now_hour, {1'b0, item_q.now_minute} + 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best         <= DIST_W'(WEEK_MIN);
      next_present <= 1'b0;
      next_index   <= '0;
      next_day     <= '0;
      next_dist    <= '0;
      ring         <= 1'b0;
      started      <= 1'b0;
      stopped      <= 1'b0;
    end else begin
      if (cmd.load) begin
        started <= 1'b0;
        stopped <= (item.req_type == REQ_STOP) && ring;
        if (item.req_type == REQ_STOP) begin
          ring <= 1'b0;
        end
      end
      if (cmd.tick_eval) begin
        ring <= ring_new && tick_match;
        if (ring_new) begin
          started <= tick_match && !ring;
          stopped <= !tick_match;
        end
      end
      if (cmd.scan_clr) begin
        best         <= DIST_W'(WEEK_MIN);
        next_present <= 1'b0;
        next_index   <= '0;
        next_day     <= '0;
        next_dist    <= '0;
      end else if (cmd.scan_eval && day_hit && (cand_dist < best)) begin
        best         <= cand_dist;
        next_present <= 1'b1;
        next_index   <= cmd.slot[IDX_W-1:0];
        next_day     <= cmd.day;
        next_dist    <= cand_dist;
      end
    end
  end

  assign next_index_ext = SLOT_W'(next_index);

  always_comb begin
    result               = '0;
    result.ringing       = ring;
    result.ring_started  = started;
    result.ring_stopped  = stopped;
    result.next_valid    = next_present;
    result.next_slot     = next_index_ext[2:0];
    result.next_weekday  = next_day;
    result.minutes_until = next_dist;
  end

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    !next_present |-> (next_index == '0 && next_day == '0 && next_dist == '0))
    else $error("next alarm fields set without a next alarm");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    next_dist < DIST_W'(WEEK_MIN)) else $error("distance beyond one week");

  a_start_stop: assert property (@(posedge clk) disable iff (rst)
    cmd.done |-> !(started && stopped) && (!started || ring))
    else $error("inconsistent ring flags");

endmodule

// ===== hdl/weekly_alarm_next_and_ring.sv =====
// top level of the weekly alarm block: sequencer plus datapath
// A request beat is taken when start is high and busy is low; busy then stays
// high until the single result beat, which appears for one cycle with done high
// and cannot be held off. Write, time-change and stop requests run a full scan
// of the table, one weekday of one slot per cycle through a single read port;
// a write first stores its entry in a write state. A tick reads the stored
// next alarm and scores it in its own evaluate state, or runs the scan as well
// when ringing ends. The table reads as all alarms disabled after reset, with
// no clearing pass. next_slot carries the low three bits of the slot.
module weekly_alarm_next_and_ring import wkalm_pkg::*; #(
  parameter int unsigned ALARM_SLOTS = 8   // 1 to 32 alarm slots
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  item,
  output logic done,
  output out_t result
);

  cmd_t    cmd;      // sequencer commands to the datapath
  status_t status;   // tick outcome back to the sequencer

  // sequencer: decodes the request and steps slot and weekday counters
  wkalm_ctrl #(
    .ALARM_SLOTS(ALARM_SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (item.req_type),
    .status   (status),
    .busy     (busy),
    .cmd      (cmd)
  );

  // datapath: alarm memory, nearest-alarm search and ring state
  wkalm_dp #(
    .ALARM_SLOTS(ALARM_SLOTS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

  // result beat strobe
  assign done = cmd.done;

endmodule
